### rtl/etbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edge trigger block capture package
// Sizes, constants and types shared by the capture block, its checker and its test.
// ----------------------------------------------------------------------------
package etbc_pkg;

  localparam int BLOCK_SAMPLES  = 32;
  localparam int CAPTURE_DEPTH  = 1024;
  localparam int CAPTURE_PASSES = 4;
  localparam int CAPTURE_TOTAL  = CAPTURE_PASSES * CAPTURE_DEPTH;

  localparam int SAMPLE_W    = 12;
  localparam int HIST_W      = 14;
  localparam int ADDR_OUT_W  = 10;
  localparam int COUNT_OUT_W = 12;

  localparam int POS_W   = $clog2(BLOCK_SAMPLES);
  localparam int DADDR_W = $clog2(CAPTURE_DEPTH);
  localparam int CNT_W   = $clog2(CAPTURE_TOTAL);

  localparam logic [HIST_W-1:0]   HIST_SENTINEL   = HIST_W'(10000);
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(1222);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [HIST_W-1:0]   hist_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage : etbc_pkg
`default_nettype wire

### rtl/etbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
module etbc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : etbc_ram
`default_nettype wire

### rtl/edge_trigger_block_capture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edge trigger block capture
// Watches ADC samples for a rising edge and bursts whole blocks to a ring.
// ----------------------------------------------------------------------------
// Samples arrive on the in_ channel, one per transfer, and are collected in
// blocks of BLOCK_SAMPLES in a small block memory. While no capture runs,
// each sample is checked against the threshold written on the cfg_ port and
// tracked in a four-entry peak history; an edge starts a capture.
// Throughput: one sample per cycle while a block fills. When a block
// completes during a capture, in_ready drops while the block is read back
// from the memory at one result transfer per cycle while the receiver is
// ready, so input pauses for every captured block, and longer while the
// receiver stalls; the single memory read port causes this pause. After the
// last sample of a block is taken, the drain state issues the read of the
// first result, which passes through the read stage to the output register.
// Each result carries ring address, sample, running count and a last flag
// on the final transfer of the burst. A stalled receiver holds the output
// register and, through it, the memory read; nothing is lost or repeated.
// After CAPTURE_PASSES * CAPTURE_DEPTH results the capture ends and the
// history returns to the sentinel. Reset restores the threshold to 1222,
// clears the history, position and capture state; the block memory needs
// no clearing as every entry is written before it is read.
// The cfg_ port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module edge_trigger_block_capture
  import etbc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [SAMPLE_W-1:0]    cfg_idle_threshold,
  // sample input
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [SAMPLE_W-1:0]    in_sample,
  // ring buffer writes
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [ADDR_OUT_W-1:0]  out_write_address,
  output      logic [SAMPLE_W-1:0]    out_write_data,
  output      logic [COUNT_OUT_W-1:0] out_write_count,
  output      logic                   out_burst_last
);

  // Control state.
  state_t                 state_r, state_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       idx_r, idx_nxt;
  sample_t                thr_r, thr_nxt;
  hist_t                  hist_r [4];
  hist_t                  hist_nxt [4];
  logic                   active_r, active_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DADDR_W-1:0]     addr_r, addr_nxt;

  // Read stage: a memory read is in flight with its metadata.
  logic                   rd_valid_r, rd_valid_nxt;
  logic [DADDR_W-1:0]     rd_addr_r;
  logic [CNT_W-1:0]       rd_count_r;
  logic                   rd_last_r;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_OUT_W-1:0]  out_addr_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  sample_t                out_data_r;
  logic                   out_last_r;

  // Handshake and decision terms.
  logic                   in_fire;
  logic                   ld;
  logic                   issue;
  logic                   issue_last;
  logic                   capture_done;
  logic                   above;
  logic                   trig;
  logic                   block_end;
  logic                   drain_ok;
  sample_t                ram_rdata;

  // The block memory is written while filling and read while draining, so
  // the two ports are never busy on the same pass.
  etbc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BLOCK_SAMPLES)
  ) u_block_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (pos_r),
    .wdata (in_sample),
    .re    (issue),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Control outputs of the state machine.
  always_comb begin
    in_ready = 1'b0;
    drain_ok = 1'b0;
    case (state_r)
      ST_FILL:  in_ready = 1'b1;
      ST_DRAIN: drain_ok = 1'b1;
      default: begin
        in_ready = 1'b0;
        drain_ok = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // A read result moves to the output register when that register is free
  // or being emptied. A new read is issued only when its result can land,
  // so the registered read data is never overwritten while it waits.
  assign ld           = rd_valid_r && (!out_valid_r || out_ready);
  assign issue        = drain_ok && (!rd_valid_r || ld);
  assign capture_done = (cnt_r == CNT_W'(CAPTURE_TOTAL - 1));
  assign issue_last   = (idx_r == POS_W'(BLOCK_SAMPLES - 1)) || capture_done;

  // Edge detection: the new sample is compared with the entry that becomes
  // the oldest one after the push, which is the current third entry.
  assign above     = in_sample > thr_r;
  assign trig      = !active_r && above && ({2'b00, in_sample} > hist_r[2]);
  assign block_end = (pos_r == POS_W'(BLOCK_SAMPLES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (in_fire && block_end && (active_r || trig)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue && issue_last) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Datapath and bookkeeping.
  always_comb begin
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    thr_nxt    = thr_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    addr_nxt   = addr_r;
    for (int k = 0; k < 4; k++) begin
      hist_nxt[k] = hist_r[k];
    end

    if (cfg_valid && cfg_ready) begin
      thr_nxt = cfg_idle_threshold;
    end

    if (in_fire) begin
      pos_nxt = block_end ? '0 : pos_r + POS_W'(1);
      idx_nxt = '0;
      if (!active_r) begin
        if (above) begin
          hist_nxt[3] = hist_r[2];
          hist_nxt[2] = hist_r[1];
          hist_nxt[1] = hist_r[0];
          hist_nxt[0] = {2'b00, in_sample};
          if (trig) begin
            active_nxt = 1'b1;
            cnt_nxt    = '0;
            addr_nxt   = '0;
          end
        end else begin
          hist_nxt[0] = HIST_SENTINEL;
        end
      end
    end

    if (issue) begin
      idx_nxt = idx_r + POS_W'(1);
      if (capture_done) begin
        // Capture complete: back to idle watching with a fresh history.
        active_nxt = 1'b0;
        cnt_nxt    = '0;
        addr_nxt   = '0;
        for (int k = 0; k < 4; k++) begin
          hist_nxt[k] = HIST_SENTINEL;
        end
      end else begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        addr_nxt = (addr_r == DADDR_W'(CAPTURE_DEPTH - 1)) ? '0 : addr_r + DADDR_W'(1);
      end
    end
  end

  assign rd_valid_nxt  = issue || (rd_valid_r && !ld);
  assign out_valid_nxt = ld || (out_valid_r && !out_ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      pos_r       <= '0;
      idx_r       <= '0;
      thr_r       <= THRESHOLD_RESET;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      addr_r      <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        hist_r[k] <= HIST_SENTINEL;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      thr_r       <= thr_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < 4; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  // Payload registers of the read stage and the output register.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr_r  <= addr_r;
      rd_count_r <= cnt_r;
      rd_last_r  <= issue_last;
    end
    if (ld) begin
      out_addr_r  <= ADDR_OUT_W'(rd_addr_r);
      out_count_r <= COUNT_OUT_W'(rd_count_r);
      out_data_r  <= ram_rdata;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_write_count   = out_count_r;
  assign out_burst_last    = out_last_r;

endmodule : edge_trigger_block_capture
`default_nettype wire

### tb/edge_trigger_block_capture_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge trigger block capture checker
// Watches the sample, threshold and ring-write channels, predicts every ring
// write from the samples taken and compares each one field by field.
// ----------------------------------------------------------------------------
module edge_trigger_block_capture_checker
  import etbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [SAMPLE_W-1:0]    cfg_idle_threshold,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_W-1:0]    in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [ADDR_OUT_W-1:0]  out_write_address,
  input  logic [SAMPLE_W-1:0]    out_write_data,
  input  logic [COUNT_OUT_W-1:0] out_write_count,
  input  logic                   out_burst_last,
  output int                     fail_count,
  output int                     pending_writes,
  output logic                   capturing,
  output int                     samples_taken,
  output int                     writes_checked,
  output int                     captures_started,
  output int                     captures_ended,
  output int                     threshold_writes
);

  typedef struct packed {
    logic [ADDR_OUT_W-1:0]  address;
    sample_t                data;
    logic [COUNT_OUT_W-1:0] count;
    logic                   last;
  } ring_write_t;

  sample_t     threshold_q;
  sample_t     block_mem [BLOCK_SAMPLES];
  hist_t       peak_hist [4];
  int          fill_pos;
  bit          capture_on;
  int          written;
  ring_write_t expected_writes [$];

  function automatic void clear_peaks();
    int k;
    for (k = 0; k < 4; k++) peak_hist[k] = HIST_SENTINEL;
  endfunction

  function automatic void reset_prediction();
    threshold_q = THRESHOLD_RESET;
    clear_peaks();
    fill_pos   = 0;
    capture_on = 1'b0;
    written    = 0;
    expected_writes.delete();
    fail_count       = 0;
    samples_taken    = 0;
    writes_checked   = 0;
    captures_started = 0;
    captures_ended   = 0;
    threshold_writes = 0;
  endfunction

  // Stores the sample, runs edge detection while idle, and at the end of a
  // block queues the burst of ring writes that a running capture produces.
  function automatic void absorb_sample(input sample_t s);
    ring_write_t w;
    int          burst;
    int          i;
    block_mem[fill_pos] = s;
    if (!capture_on) begin
      if (s > threshold_q) begin
        peak_hist[3] = peak_hist[2];
        peak_hist[2] = peak_hist[1];
        peak_hist[1] = peak_hist[0];
        peak_hist[0] = hist_t'(s);
        if (hist_t'(s) > peak_hist[3]) begin
          capture_on = 1'b1;
          written    = 0;
          captures_started++;
        end
      end else begin
        peak_hist[0] = HIST_SENTINEL;
      end
    end
    fill_pos++;
    if (fill_pos < BLOCK_SAMPLES) return;
    fill_pos = 0;
    if (!capture_on) return;
    burst = 0;
    for (i = 0; i < BLOCK_SAMPLES && written < CAPTURE_TOTAL; i++) begin
      w.address = ADDR_OUT_W'(written % CAPTURE_DEPTH);
      w.data    = block_mem[i];
      w.count   = COUNT_OUT_W'(written);
      w.last    = 1'b0;
      expected_writes.push_back(w);
      written++;
      burst++;
    end
    if (burst > 0) begin
      w      = expected_writes.pop_back();
      w.last = 1'b1;
      expected_writes.push_back(w);
    end
    if (written >= CAPTURE_TOTAL) begin
      clear_peaks();
      capture_on = 1'b0;
      written    = 0;
      captures_ended++;
    end
  endfunction

  function automatic void check_ring_write();
    ring_write_t want;
    if (expected_writes.size() == 0) begin
      $error("Ring write with nothing expected: address %0d, data %0d",
             out_write_address, out_write_data);
      fail_count++;
      return;
    end
    want = expected_writes.pop_front();
    writes_checked++;
    if (out_write_address !== want.address) begin
      $error("write_address: expected %0d, got %0d", want.address, out_write_address);
      fail_count++;
    end
    if (out_write_data !== want.data) begin
      $error("write_data: expected %0d, got %0d", want.data, out_write_data);
      fail_count++;
    end
    if (out_write_count !== want.count) begin
      $error("write_count: expected %0d, got %0d", want.count, out_write_count);
      fail_count++;
    end
    if (out_burst_last !== want.last) begin
      $error("burst_last: expected %0d, got %0d", want.last, out_burst_last);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_prediction();
    end else begin
      if (out_valid && out_ready) check_ring_write();
      if (cfg_valid && cfg_ready) begin
        threshold_q = cfg_idle_threshold;
        threshold_writes++;
      end
      if (in_valid && in_ready) begin
        absorb_sample(in_sample);
        samples_taken++;
      end
    end
    pending_writes = expected_writes.size();
    capturing      = capture_on;
  end

endmodule

### tb/edge_trigger_block_capture_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge trigger block capture test
// Drives samples and threshold writes into the capture block with random
// gaps and receiver stalls, while a checker beside it predicts every ring
// write and reports mismatches.
// ----------------------------------------------------------------------------
// The run opens with a hand-made block at the reset threshold: field
// extremes, a flat run and a run broken by a low sample, none of which may
// trigger, so the first block stays idle. The second block uses a random
// threshold and only falling levels mixed with low samples, so it stays idle
// as well. The third block, back at the reset threshold, carries a rising
// run part-way through which starts a capture, so the whole block is
// written. Two more blocks of random samples follow while the capture runs,
// the last without gaps or stalls, and a partial block ends the run.
// ----------------------------------------------------------------------------
module edge_trigger_block_capture_test;
  import etbc_pkg::*;

  localparam int      CYCLE_LIMIT = 1_000_000;
  localparam int      DRAIN_SLACK = 8;
  localparam int      END_SLACK   = BLOCK_SAMPLES + 16;
  localparam int      SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int      TAIL_ITEMS  = 10;
  // The quiet block keeps every level at or below the lowest history entry
  // left by the first block, so no sample can exceed an older entry.
  localparam int      QUIET_TOP     = 1800;
  localparam int      QUIET_THR_MIN = 1000;
  localparam int      QUIET_THR_MAX = 1700;
  localparam int      EDGE_FREE_LEN = 14;
  // Extremes and threshold boundaries, a flat run, a falling sample and a
  // run that restarts after a low sample: none of these may start a capture.
  localparam int      EDGE_FREE_SEQ [EDGE_FREE_LEN] =
    '{0, 4095, 1222, 1223, 100, 2000, 2000, 2000, 2000, 1900, 1000, 1800, 1900, 1222};

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SAMPLE_W-1:0]    cfg_idle_threshold;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    in_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [ADDR_OUT_W-1:0]  out_write_address;
  logic [SAMPLE_W-1:0]    out_write_data;
  logic [COUNT_OUT_W-1:0] out_write_count;
  logic                   out_burst_last;

  int   fail_count;
  int   pending_writes;
  logic capturing;
  int   samples_taken;
  int   writes_checked;
  int   captures_started;
  int   captures_ended;
  int   threshold_writes;

  bit   calm;         // set for the last phase: no gaps and no stalls
  int   block_fill;   // samples transferred into the current block
  int   cycle_count;

  edge_trigger_block_capture u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_idle_threshold (cfg_idle_threshold),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_write_count    (out_write_count),
    .out_burst_last     (out_burst_last)
  );

  edge_trigger_block_capture_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_idle_threshold (cfg_idle_threshold),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_write_count    (out_write_count),
    .out_burst_last     (out_burst_last),
    .fail_count         (fail_count),
    .pending_writes     (pending_writes),
    .capturing          (capturing),
    .samples_taken      (samples_taken),
    .writes_checked     (writes_checked),
    .captures_started   (captures_started),
    .captures_ended     (captures_ended),
    .threshold_writes   (threshold_writes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The watchdog ends a run that hangs; the limit is many times the slowest
  // correct run.
  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles with %0d ring writes outstanding.",
             cycle_count, pending_writes);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver stalls in short random bursts between stretches of
  // readiness, and stays ready throughout the last phase.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // One sample transfer, sometimes preceded by a short gap. The payload is
  // held until the block takes it, which may be a long while during a burst.
  task automatic feed_sample(input sample_t s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    block_fill = (block_fill + 1) % BLOCK_SAMPLES;
  endtask

  task automatic write_threshold(input sample_t value);
    cfg_valid          <= 1'b1;
    cfg_idle_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted write has been transferred, then gives the
  // block a few more cycles in case its last block produced no burst.
  task automatic settle();
    do @(negedge clk); while (pending_writes != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  initial begin
    sample_t quiet_thr;
    sample_t level;
    int      i;
    rst_n              <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_idle_threshold <= '0;
    in_valid           <= 1'b0;
    in_sample          <= '0;
    calm       = 1'b0;
    block_fill = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First block at the reset threshold: nothing in it may start a capture,
    // so it must end without a burst. Low samples pad it out.
    for (i = 0; i < EDGE_FREE_LEN; i++) feed_sample(sample_t'(EDGE_FREE_SEQ[i]));
    while (block_fill != 0) feed_sample(sample_t'($urandom_range(0, THRESHOLD_RESET)));
    in_valid <= 1'b0;
    settle();

    // Second block at a random threshold: levels above it only ever fall,
    // broken now and then by a low sample, so no edge is seen.
    quiet_thr = sample_t'($urandom_range(QUIET_THR_MIN, QUIET_THR_MAX));
    write_threshold(quiet_thr);
    level = sample_t'(QUIET_TOP);
    for (i = 0; i < BLOCK_SAMPLES; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        feed_sample(sample_t'($urandom_range(0, quiet_thr)));
      end else begin
        level = sample_t'($urandom_range(int'(quiet_thr) + 1, level));
        feed_sample(level);
      end
    end
    in_valid <= 1'b0;
    settle();

    // Third block: a rising run part-way through starts a capture, at the
    // latest on its fourth sample, and the whole block, including the
    // samples before the edge, is written.
    write_threshold(THRESHOLD_RESET);
    for (i = 0; i < 10; i++) feed_sample(sample_t'($urandom_range(0, THRESHOLD_RESET)));
    feed_sample(sample_t'(1300));
    feed_sample(sample_t'(1400));
    feed_sample(sample_t'(1500));
    feed_sample(sample_t'(1600));
    while (block_fill != 0) feed_sample(sample_t'($urandom_range(0, SAMPLE_MAX)));

    // The capture keeps running: each further block is written in full.
    for (i = 0; i < BLOCK_SAMPLES; i++) feed_sample(sample_t'($urandom_range(0, SAMPLE_MAX)));
    calm = 1'b1;
    for (i = 0; i < BLOCK_SAMPLES; i++) feed_sample(sample_t'($urandom_range(0, SAMPLE_MAX)));
    // A partial block produces nothing yet.
    for (i = 0; i < TAIL_ITEMS; i++) feed_sample(sample_t'($urandom_range(0, SAMPLE_MAX)));
    in_valid <= 1'b0;

    do @(negedge clk); while (pending_writes != 0);
    repeat (END_SLACK) @(posedge clk);
    @(negedge clk);

    $display("Took %0d samples under %0d threshold settings; %0d captures began, %0d ran out.",
             samples_taken, threshold_writes + 1, captures_started, captures_ended);
    $display("Compared %0d ring writes with their predictions; %0d mismatches.",
             writes_checked, fail_count);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
